### hw/rtl/dpvt_pkg.sv
`default_nettype none

package dpvt_pkg;

    // default configuration of the tracker
    localparam int DEFAULT_TAU_MS      = 200;
    localparam int DEFAULT_TABLE_LEN   = 2048;
    localparam int DEFAULT_SAMPLE_BITS = 12;

    // timestamp width, fixed by the interface
    localparam int TIME_BITS = 32;

    // decay factor format, Q1.16
    localparam int FACTOR_BITS = 17;
    localparam int FACTOR_FRAC = 16;

    // series terms used to build exp(-1/tau) in Q0.31
    localparam int TAYLOR_TERMS = 12;

    // which half of the item a pipeline slot is working on
    typedef enum logic {
        PH_PEAK   = 1'b0,
        PH_VALLEY = 1'b1
    } phase_t;

endpackage : dpvt_pkg

`default_nettype wire

### hw/rtl/decaying_peak_valley_tracker.sv
`default_nettype none

// Peak and valley tracker with exponential decay toward a filtered level.
// Each item carries a mode bit, a filtered level, a raw sample and a
// millisecond timestamp; each item gives exactly one result holding the
// decayed peak and the decayed valley after that update. The decay factor
// exp(-dt/tau) comes from a Q1.16 table of DECAY_TABLE_LEN entries held in
// a synchronous ROM and built at elaboration from DECAY_TAU_MS; beyond the
// table the factor is zero, so a late update (or time running backward)
// snaps the decayed value to the level. Mode 1 clears both anchors and
// decayed values but keeps the capture times. The single ROM read port and
// the single multiplier are used once for the peak and once for the valley
// of each item; a new item can enter while the previous one does its valley
// read. An accepted item passes the read and compute stages into the output
// register, which lets the next item enter while a result waits to be taken.
module decaying_peak_valley_tracker
    import dpvt_pkg::*;
#(
    parameter int DECAY_TAU_MS    = DEFAULT_TAU_MS,
    parameter int DECAY_TABLE_LEN = DEFAULT_TABLE_LEN,
    parameter int SAMPLE_BITS     = DEFAULT_SAMPLE_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // item input channel
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   mode,
    input  wire logic [SAMPLE_BITS-1:0] filtered_level,
    input  wire logic [SAMPLE_BITS-1:0] raw_sample,
    input  wire logic [TIME_BITS-1:0]   time_ms,

    // result channel
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [SAMPLE_BITS-1:0]      peak_value,
    output logic [SAMPLE_BITS-1:0]      valley_value
);

    localparam int AW        = $clog2(DECAY_TABLE_LEN);
    localparam int PROD_BITS = SAMPLE_BITS + FACTOR_BITS;
    localparam logic [63:0] Q31_ONE = 64'd1 << 31;
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0] TABLE_END = TIME_BITS'(DECAY_TABLE_LEN);

    typedef logic [FACTOR_BITS-1:0] rom_t [DECAY_TABLE_LEN];

    // decay table: E(k) = exp(-k/tau) in Q1.16, built with the same
    // fixed-point series and rounding that define the behavior
    function automatic rom_t build_rom();
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] e;
        rom_t        rom;
        x    = (Q31_ONE + 64'(DECAY_TAU_MS / 2)) / 64'(DECAY_TAU_MS);
        term = Q31_ONE;
        s    = Q31_ONE;
        e    = Q31_ONE;
        for (int n = 1; n < TAYLOR_TERMS; n++)
        begin
            term = ((term * x) >> 31) / 64'(n);
            if (n[0])
            begin
                s = (s >= term) ? s - term : 64'd0;
            end
            else
            begin
                s = s + term;
            end
        end
        if (s > Q31_ONE)
        begin
            s = Q31_ONE;
        end
        for (int k = 0; k < DECAY_TABLE_LEN; k++)
        begin
            rom[k] = FACTOR_BITS'((e + (64'd1 << 14)) >> 15);
            e      = (e * s) >> 31;
        end
        return rom;
    endfunction

    localparam rom_t DECAY_ROM = build_rom();

    // ------------------------------------------------------------------
    // read stage: holds the item for a peak phase and a valley phase, one table read per phase
    // ------------------------------------------------------------------
    logic                   r_valid_reg, r_valid_next;
    phase_t                 r_ph_reg, r_ph_next;
    logic                   r_mode_reg;
    logic [SAMPLE_BITS-1:0] r_level_reg;
    logic [SAMPLE_BITS-1:0] r_sample_reg;
    logic [TIME_BITS-1:0]   r_time_reg;

    // compute stage: consumes the registered table word from the read stage
    logic                   x_valid_reg, x_valid_next;
    phase_t                 x_ph_reg, x_ph_next;
    logic                   x_mode_reg;
    logic [SAMPLE_BITS-1:0] x_level_reg;
    logic [SAMPLE_BITS-1:0] x_sample_reg;
    logic [TIME_BITS-1:0]   x_time_reg;

    // registered ROM output and its in-range flag
    logic [FACTOR_BITS-1:0] rom_q_reg;
    logic                   rom_hit_reg;

    // tracker state
    logic [SAMPLE_BITS-1:0] peak_anchor_reg, peak_anchor_next;
    logic [SAMPLE_BITS-1:0] valley_anchor_reg, valley_anchor_next;
    logic [TIME_BITS-1:0]   peak_time_reg, peak_time_next;
    logic [TIME_BITS-1:0]   valley_time_reg, valley_time_next;
    logic [SAMPLE_BITS-1:0] peak_decayed_reg, peak_decayed_next;
    logic [SAMPLE_BITS-1:0] valley_decayed_reg, valley_decayed_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_peak_reg, out_peak_next;
    logic [SAMPLE_BITS-1:0] out_valley_reg, out_valley_next;

    logic                   adv;
    logic                   in_take;
    logic [TIME_BITS-1:0]   rd_dt;
    logic                   rd_hit;
    logic [AW-1:0]          rd_addr;

    logic [FACTOR_BITS-1:0] factor;
    logic [SAMPLE_BITS-1:0] mul_a;
    logic [PROD_BITS-1:0]   prod;
    logic [SAMPLE_BITS-1:0] scaled;
    logic                   pk_above;
    logic                   vl_below;
    logic [SAMPLE_BITS-1:0] pk_dec;
    logic [SAMPLE_BITS-1:0] vl_dec;
    logic                   pk_cap;
    logic                   vl_cap;
    logic                   x_fire;

    // the whole pipe holds only when a finished result cannot leave
    assign adv = !(x_valid_reg && (x_ph_reg == PH_VALLEY) && out_valid_reg && !out_ready);

    // a new item enters when the read stage is empty or finishing its valley read
    assign in_ready = adv && (!r_valid_reg || (r_ph_reg == PH_VALLEY));
    assign in_take  = in_valid && in_ready;

    // read stage control
    always_comb
    begin
        r_valid_next = r_valid_reg;
        r_ph_next    = r_ph_reg;
        if (adv)
        begin
            if (r_valid_reg && (r_ph_reg == PH_PEAK))
            begin
                r_ph_next = PH_VALLEY;
            end
            else if (in_take)
            begin
                r_valid_next = 1'b1;
                r_ph_next    = PH_PEAK;
            end
            else
            begin
                r_valid_next = 1'b0;
                r_ph_next    = PH_PEAK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            r_ph_reg    <= PH_PEAK;
        end
        else
        begin
            r_valid_reg <= r_valid_next;
            r_ph_reg    <= r_ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            r_mode_reg   <= mode;
            r_level_reg  <= filtered_level;
            r_sample_reg <= raw_sample;
            r_time_reg   <= time_ms;
        end
    end

    // table address: elapsed time since the capture of the anchor in turn;
    // the peak side is always written back before the next item reads it,
    // and the valley side likewise, so no forwarding is needed
    assign rd_dt   = r_time_reg - ((r_ph_reg == PH_PEAK) ? peak_time_reg : valley_time_reg);
    assign rd_hit  = rd_dt < TABLE_END;
    assign rd_addr = rd_hit ? rd_dt[AW-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rom_q_reg   <= DECAY_ROM[rd_addr];
            rom_hit_reg <= rd_hit;
        end
    end

    // compute stage control takes the read stage's valid and phase on each advance
    always_comb
    begin
        x_valid_next = x_valid_reg;
        x_ph_next    = x_ph_reg;
        if (adv)
        begin
            x_valid_next = r_valid_reg;
            x_ph_next    = r_ph_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= 1'b0;
            x_ph_reg    <= PH_PEAK;
        end
        else
        begin
            x_valid_reg <= x_valid_next;
            x_ph_reg    <= x_ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_mode_reg   <= r_mode_reg;
            x_level_reg  <= r_level_reg;
            x_sample_reg <= r_sample_reg;
            x_time_reg   <= r_time_reg;
        end
    end

    // shared decay multiplier: (anchor distance) * factor, truncated Q1.16
    // the scaled term never exceeds the distance, so it fits the sample width
    assign factor   = rom_hit_reg ? rom_q_reg : '0;
    assign pk_above = peak_anchor_reg > x_level_reg;
    assign vl_below = valley_anchor_reg < x_level_reg;
    assign mul_a    = (x_ph_reg == PH_PEAK) ? (peak_anchor_reg - x_level_reg)
                                            : (x_level_reg - valley_anchor_reg);
    assign prod     = PROD_BITS'(mul_a) * PROD_BITS'(factor);
    assign scaled   = prod[FACTOR_FRAC +: SAMPLE_BITS];

    // decayed candidates; when an anchor is not beyond the level, the previous decayed value is kept
    assign pk_dec = pk_above ? (x_level_reg + scaled) : peak_decayed_reg;
    assign vl_dec = vl_below ? (x_level_reg - scaled) : valley_decayed_reg;
    assign pk_cap = pk_dec <= x_sample_reg;
    assign vl_cap = vl_dec >= x_sample_reg;

    assign x_fire = adv && x_valid_reg;

    // peak state written back in the peak phase
    always_comb
    begin
        peak_anchor_next  = peak_anchor_reg;
        peak_time_next    = peak_time_reg;
        peak_decayed_next = peak_decayed_reg;
        if (x_fire && (x_ph_reg == PH_PEAK))
        begin
            if (x_mode_reg)
            begin
                // clear: anchor and decayed value to zero, capture time kept
                peak_anchor_next  = '0;
                peak_decayed_next = '0;
            end
            else if (pk_cap)
            begin
                // sample reached the decayed peak: re-capture
                peak_anchor_next  = x_sample_reg;
                peak_decayed_next = x_sample_reg;
                peak_time_next    = x_time_reg;
            end
            else
            begin
                peak_decayed_next = pk_dec;
            end
        end
    end

    // valley state written back in the valley phase
    always_comb
    begin
        valley_anchor_next  = valley_anchor_reg;
        valley_time_next    = valley_time_reg;
        valley_decayed_next = valley_decayed_reg;
        if (x_fire && (x_ph_reg == PH_VALLEY))
        begin
            if (x_mode_reg)
            begin
                // clear: anchor and decayed value to full scale
                valley_anchor_next  = FULL_SCALE;
                valley_decayed_next = FULL_SCALE;
            end
            else if (vl_cap)
            begin
                // sample reached the decayed valley: re-capture
                valley_anchor_next  = x_sample_reg;
                valley_decayed_next = x_sample_reg;
                valley_time_next    = x_time_reg;
            end
            else
            begin
                valley_decayed_next = vl_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_anchor_reg    <= '0;
            valley_anchor_reg  <= FULL_SCALE;
            peak_time_reg      <= '0;
            valley_time_reg    <= '0;
            peak_decayed_reg   <= '0;
            valley_decayed_reg <= FULL_SCALE;
        end
        else
        begin
            peak_anchor_reg    <= peak_anchor_next;
            valley_anchor_reg  <= valley_anchor_next;
            peak_time_reg      <= peak_time_next;
            valley_time_reg    <= valley_time_next;
            peak_decayed_reg   <= peak_decayed_next;
            valley_decayed_reg <= valley_decayed_next;
        end
    end

    // result is formed when the valley phase finishes; the peak of the same
    // item was written back in the cycle before
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_peak_next   = out_peak_reg;
        out_valley_next = out_valley_reg;
        if (x_fire && (x_ph_reg == PH_VALLEY))
        begin
            out_valid_next  = 1'b1;
            out_peak_next   = peak_decayed_reg;
            out_valley_next = valley_decayed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_peak_reg   <= out_peak_next;
        out_valley_reg <= out_valley_next;
    end

    assign out_valid    = out_valid_reg;
    assign peak_value   = out_peak_reg;
    assign valley_value = out_valley_reg;

`ifndef SYNTH
    // a new item never displaces one that still needs its valley read
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !(r_valid_reg && (r_ph_reg == PH_PEAK)))
        else $error("item accepted while read stage busy with a peak read");

    // decay only moves the peak down from its anchor
    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        peak_decayed_reg <= peak_anchor_reg)
        else $error("decayed peak above its anchor");

    // decay only moves the valley up from its anchor
    a_valley_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valley_decayed_reg >= valley_anchor_reg)
        else $error("decayed valley below its anchor");

    // a result appears only after a valley phase completed
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(x_valid_reg && (x_ph_reg == PH_VALLEY)))
        else $error("result without a finished item");
`endif

endmodule : decaying_peak_valley_tracker

`default_nettype wire
